FILE: design/max_call_payoff_accumulator_core_macros.svh
// Assertion macros used by the checker file.
`ifndef MAX_CALL_PAYOFF_ACCUMULATOR_CORE_MACROS_SVH
`define MAX_CALL_PAYOFF_ACCUMULATOR_CORE_MACROS_SVH

// Next-cycle implication, ignored while reset is high
`define MCPA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mcpa check failed");

// Next-cycle implication that also holds across reset
`define MCPA_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("mcpa check failed");

`endif

FILE: design/mcpa_pkg.sv
// Package: types, constants and helpers of the max-call payoff accumulator.
`timescale 1ns / 1ps
package mcpa_pkg;

   localparam int MAX_STOCKS = 64;
   localparam int IDX_W = $clog2(MAX_STOCKS);
   localparam int ENTRY_W = 32 + 31 + 32;

   localparam logic signed [32:0] LOG2E_Q30 = 33'sd1549082005;
   localparam logic signed [32:0] LN2_Q30 = 33'sd744261118;
   localparam logic signed [36:0] EXP_LIMIT = 37'sd385875968;
   localparam logic [3:0] TERMS = 4'd10;

   typedef enum logic [0:0] {
      CSR_BASKET_SIZE = 1'b0,
      CSR_STRIKE      = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_D, S_EX, S_Y, S_TI, S_TM, S_TV, S_CR,
      S_PR, S_SH, S_UPD, S_FIN
   } state_type;

   typedef struct packed {
      logic              func;
      logic [5:0]        stock_index;
      logic signed [31:0] drift_term;
      logic [30:0]       vol_root_time;
      logic [31:0]       spot_price;
      logic signed [23:0] gauss_sample;
   } req_type;

   typedef struct packed {
      logic [32:0] path_payoff;
      logic [63:0] payoff_sum;
      logic [39:0] path_count;
   } rsp_type;

   // floor(2^32 / i) for the series divisor, i = 2..10
   function automatic logic [31:0] recip(input logic [3:0] i);
      logic [31:0] r;
      case (i)
         4'd2:    r = 32'd2147483648;
         4'd3:    r = 32'd1431655765;
         4'd4:    r = 32'd1073741824;
         4'd5:    r = 32'd858993459;
         4'd6:    r = 32'd715827882;
         4'd7:    r = 32'd613566756;
         4'd8:    r = 32'd536870912;
         4'd9:    r = 32'd477218588;
         4'd10:   r = 32'd429496729;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/mcpa_tables.sv
// Per-stock constant store: drift, vol*sqrt(t) and spot in one wide memory.
`timescale 1ns / 1ps
module mcpa_tables (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [mcpa_pkg::IDX_W-1:0]        wr_addr,
   input  logic [mcpa_pkg::ENTRY_W-1:0]      wr_data,
   input  logic                              rd_en,
   input  logic [mcpa_pkg::IDX_W-1:0]        rd_addr,
   output logic [mcpa_pkg::ENTRY_W-1:0]      rd_data
);

   logic [mcpa_pkg::ENTRY_W-1:0] mem [mcpa_pkg::MAX_STOCKS];
   logic [mcpa_pkg::ENTRY_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mcpa_mult.sv
// Shared signed 33x33 multiplier with registered product.
`timescale 1ns / 1ps
module mcpa_mult (
   input  logic               clock,
   input  logic signed [32:0] mul_a,
   input  logic signed [32:0] mul_b,
   output logic signed [65:0] product
);

   logic signed [65:0] product_ff;
   logic signed [65:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

FILE: design/max_call_payoff_accumulator_core.sv
// Top level: sequencer and datapath of the max-call payoff accumulator.
// Usage:
//  - csr_*: register writes (basket size, strike), always ready; write only
//    while the block is idle.
//  - req_*: one request per handshake. A load request writes one stock's
//    constants into the table; loads can follow each other every cycle while idle.
//    A sample request brings one Gaussian draw for the next stock of the path.
//  - rsp_*: one response after the last sample of each path, carrying the
//    path payoff, saturating running sum and path count.
// Timing: a sample request holds req_ready low until it is done, so a
//  new sample is not taken before the last one is through: two exponentials
//  on the single shared multiplier (one multiply for the first series term, a
//  multiply and a corrected reciprocal divide for each of the other nine),
//  plus the vol product. An exponent clipped at +-23 skips the series. The
//  final sample of a path also passes through the FIN state, which registers
//  its response once the output register is free.
// Reset clears path position, maxima, sum, count and registers; the table
//  holds garbage until loaded. If the receiver stalls, the response is
//  held in its output register; the next path runs meanwhile and only
//  waits at its end if the previous response is still unclaimed.
`timescale 1ns / 1ps
module max_call_payoff_accumulator_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mcpa_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mcpa_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  mcpa_pkg::csr_index_type   csr_index,
   input  logic [31:0]               csr_wdata
);

   mcpa_pkg::state_type state_ff, state_in;

   logic [5:0]         pos_ff, pos_in;
   logic [31:0]        max_up_ff, max_up_in, max_dn_ff, max_dn_in;
   logic [63:0]        sum_ff, sum_in;
   logic [39:0]        cnt_ff, cnt_in;
   logic [6:0]         count_ff;
   logic [31:0]        strike_ff;
   logic signed [23:0] g_ff, g_in;
   logic signed [36:0] xup_ff, xup_in, xdn_ff, xdn_in;
   logic               side_ff, side_in;
   logic signed [6:0]  n_ff, n_in;
   logic [30:0]        term_ff, term_in, mant_ff, mant_in;
   logic [29:0]        t_ff, t_in, v_ff, v_in;
   logic [3:0]         i_ff, i_in;
   logic [31:0]        price_ff, price_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mcpa_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic                  req_acc, sample_acc, load_acc;
   logic [mcpa_pkg::ENTRY_W-1:0] rd_entry;
   logic signed [31:0]    rd_drift;
   logic [30:0]           rd_vol;
   logic [31:0]           rd_spot;
   logic signed [32:0]    mul_a, mul_b;
   logic signed [65:0]    prod;
   logic [23:0]           g_mag;
   logic [34:0]           d_mag;
   logic signed [36:0]    d_sgn, x_sel;
   logic                  x_high, x_low;
   logic [6:0]            count_use;
   logic                  last_pos, out_free;
   logic [29:0]           q0, q_fix;
   logic [31:0]           rem;
   logic signed [7:0]     shr;
   logic [62:0]           shifted, spot_prod;
   logic [1:0]            shl;
   logic [31:0]           pay_up, pay_dn;
   logic [32:0]           payoff;
   logic [64:0]           sum_wide;

   // handshakes
   assign req_ready  = (state_ff == mcpa_pkg::S_IDLE);
   assign req_acc    = req_valid && req_ready;
   assign sample_acc = req_acc && req_data.func;
   assign load_acc   = req_acc && !req_data.func;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 7'd1;
         strike_ff <= 32'd0;
      end else if (csr_valid) begin
         case (csr_index)
            mcpa_pkg::CSR_BASKET_SIZE: count_ff  <= csr_wdata[6:0];
            mcpa_pkg::CSR_STRIKE:      strike_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign count_use = (count_ff == 7'd0) ? 7'd1 :
                      (count_ff > 7'(mcpa_pkg::MAX_STOCKS)) ?
                      7'(mcpa_pkg::MAX_STOCKS) : count_ff;
   assign last_pos  = !(({1'b0, pos_ff} + 7'd1) < count_use);

   // stock constant table
   mcpa_tables u_tables (
      .clock   (clock),
      .wr_en   (load_acc),
      .wr_addr (req_data.stock_index),
      .wr_data ({req_data.drift_term, req_data.vol_root_time, req_data.spot_price}),
      .rd_en   (sample_acc),
      .rd_addr (pos_ff),
      .rd_data (rd_entry)
   );

   assign rd_drift = rd_entry[94:63];
   assign rd_vol   = rd_entry[62:32];
   assign rd_spot  = rd_entry[31:0];

   // shared multiplier
   mcpa_mult u_mult (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (prod)
   );

   // exponent arithmetic helpers
   assign g_mag  = g_ff[23] ? 24'(-g_ff) : 24'(g_ff);
   assign d_mag  = 35'((prod[54:0] + 55'd524288) >> 20);
   assign d_sgn  = g_ff[23] ? -$signed({2'b00, d_mag}) : $signed({2'b00, d_mag});
   assign x_sel  = side_ff ? xdn_ff : xup_ff;
   assign x_high = (x_sel >= mcpa_pkg::EXP_LIMIT);
   assign x_low  = (x_sel <= -mcpa_pkg::EXP_LIMIT);

   // series divide correction
   assign q0    = prod[61:32];
   assign rem   = {2'b00, v_ff} - 32'(q0 * i_ff);
   assign q_fix = (rem >= {28'd0, i_ff}) ? q0 + 30'd1 : q0;

   // spot scaling by 2^(n-30)
   assign spot_prod = prod[62:0];
   assign shr       = 8'sd30 - 8'(n_ff);
   assign shl       = 2'(n_ff - 7'sd30);
   assign shifted   = spot_prod >> shr[5:0];

   // end of path payoff
   assign pay_up   = (max_up_ff > strike_ff) ? max_up_ff - strike_ff : 32'd0;
   assign pay_dn   = (max_dn_ff > strike_ff) ? max_dn_ff - strike_ff : 32'd0;
   assign payoff   = {1'b0, pay_up} + {1'b0, pay_dn};
   assign sum_wide = {1'b0, sum_ff} + {32'd0, payoff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcpa_pkg::S_IDLE: if (sample_acc) state_in = mcpa_pkg::S_RD;
         mcpa_pkg::S_RD:   state_in = mcpa_pkg::S_D;
         mcpa_pkg::S_D:    state_in = mcpa_pkg::S_EX;
         mcpa_pkg::S_EX:   state_in = (x_high || x_low) ? mcpa_pkg::S_UPD : mcpa_pkg::S_Y;
         mcpa_pkg::S_Y:    state_in = mcpa_pkg::S_TI;
         mcpa_pkg::S_TI:   state_in = mcpa_pkg::S_TM;
         mcpa_pkg::S_TM:   state_in = mcpa_pkg::S_TV;
         mcpa_pkg::S_TV:   state_in = (i_ff == 4'd1) ? mcpa_pkg::S_TM : mcpa_pkg::S_CR;
         mcpa_pkg::S_CR:   state_in = (i_ff == mcpa_pkg::TERMS) ? mcpa_pkg::S_PR
                                                                : mcpa_pkg::S_TM;
         mcpa_pkg::S_PR:   state_in = mcpa_pkg::S_SH;
         mcpa_pkg::S_SH:   state_in = mcpa_pkg::S_UPD;
         mcpa_pkg::S_UPD: begin
            if (!side_ff)      state_in = mcpa_pkg::S_EX;
            else if (last_pos) state_in = mcpa_pkg::S_FIN;
            else               state_in = mcpa_pkg::S_IDLE;
         end
         mcpa_pkg::S_FIN:  if (out_free) state_in = mcpa_pkg::S_IDLE;
         default:          state_in = mcpa_pkg::S_IDLE;
      endcase
   end

   // datapath and multiplier operands
   always_comb begin
      pos_in       = pos_ff;
      max_up_in    = max_up_ff;
      max_dn_in    = max_dn_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      g_in         = g_ff;
      xup_in       = xup_ff;
      xdn_in       = xdn_ff;
      side_in      = side_ff;
      n_in         = n_ff;
      term_in      = term_ff;
      mant_in      = mant_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      i_in         = i_ff;
      price_in     = price_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = 33'sd0;
      mul_b        = 33'sd0;
      case (state_ff)
         mcpa_pkg::S_IDLE: begin
            if (sample_acc) g_in = req_data.gauss_sample;
         end
         mcpa_pkg::S_RD: begin
            mul_a = $signed({9'd0, g_mag});
            mul_b = $signed({2'b00, rd_vol});
         end
         mcpa_pkg::S_D: begin
            xup_in  = 37'(rd_drift) + d_sgn;
            xdn_in  = 37'(rd_drift) - d_sgn;
            side_in = 1'b0;
         end
         mcpa_pkg::S_EX: begin
            // clipped exponents skip the series
            if (x_high)     price_in = (rd_spot != 32'd0) ? 32'hFFFFFFFF : 32'd0;
            else if (x_low) price_in = 32'd0;
            mul_a = x_sel[32:0];
            mul_b = mcpa_pkg::LOG2E_Q30;
         end
         mcpa_pkg::S_Y: begin
            n_in  = prod[60:54];
            mul_a = $signed({3'd0, prod[53:24]});
            mul_b = mcpa_pkg::LN2_Q30;
         end
         mcpa_pkg::S_TI: begin
            t_in    = prod[59:30];
            term_in = 31'h40000000;
            mant_in = 31'h40000000;
            i_in    = 4'd1;
         end
         mcpa_pkg::S_TM: begin
            mul_a = $signed({2'b00, term_ff});
            mul_b = $signed({3'd0, t_ff});
         end
         mcpa_pkg::S_TV: begin
            v_in = prod[59:30];
            if (i_ff == 4'd1) begin
               term_in = {1'b0, prod[59:30]};
               mant_in = mant_ff + {1'b0, prod[59:30]};
               i_in    = 4'd2;
            end
            mul_a = $signed({3'd0, prod[59:30]});
            mul_b = $signed({1'b0, mcpa_pkg::recip(i_ff)});
         end
         mcpa_pkg::S_CR: begin
            term_in = {1'b0, q_fix};
            mant_in = mant_ff + {1'b0, q_fix};
            i_in    = i_ff + 4'd1;
         end
         mcpa_pkg::S_PR: begin
            mul_a = $signed({1'b0, rd_spot});
            mul_b = $signed({2'b00, mant_ff});
         end
         mcpa_pkg::S_SH: begin
            if (n_ff >= 7'sd30) begin
               if (spot_prod > 63'(32'hFFFFFFFF >> shl)) price_in = 32'hFFFFFFFF;
               else                                       price_in = 32'(spot_prod << shl);
            end else if (shr >= 8'sd64) begin
               price_in = 32'd0;
            end else if (shifted[62:32] != 31'd0) begin
               price_in = 32'hFFFFFFFF;
            end else begin
               price_in = shifted[31:0];
            end
         end
         mcpa_pkg::S_UPD: begin
            if (!side_ff) begin
               if (price_ff > max_up_ff) max_up_in = price_ff;
               side_in = 1'b1;
            end else begin
               if (price_ff > max_dn_ff) max_dn_in = price_ff;
               side_in = 1'b0;
               if (!last_pos) pos_in = pos_ff + 6'd1;
            end
         end
         mcpa_pkg::S_FIN: begin
            if (out_free) begin
               sum_in                  = sum_wide[64] ? 64'hFFFFFFFFFFFFFFFF : sum_wide[63:0];
               cnt_in                  = cnt_ff + 40'd1;
               rsp_valid_in            = 1'b1;
               rsp_data_in.path_payoff = payoff;
               rsp_data_in.payoff_sum  = sum_wide[64] ? 64'hFFFFFFFFFFFFFFFF
                                                      : sum_wide[63:0];
               rsp_data_in.path_count  = cnt_ff + 40'd1;
               pos_in                  = 6'd0;
               max_up_in               = 32'd0;
               max_dn_in               = 32'd0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcpa_pkg::S_IDLE;
         pos_ff       <= 6'd0;
         max_up_ff    <= 32'd0;
         max_dn_ff    <= 32'd0;
         sum_ff       <= 64'd0;
         cnt_ff       <= 40'd0;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         max_up_ff    <= max_up_in;
         max_dn_ff    <= max_dn_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      g_ff        <= g_in;
      xup_ff      <= xup_in;
      xdn_ff      <= xdn_in;
      n_ff        <= n_in;
      term_ff     <= term_in;
      mant_ff     <= mant_in;
      t_ff        <= t_in;
      v_ff        <= v_in;
      i_ff        <= i_in;
      price_ff    <= price_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/mcpa_checker.sv
// Port-level checker for the max-call payoff accumulator, bound to the top.
`timescale 1ns / 1ps
`include "max_call_payoff_accumulator_core_macros.svh"
module mcpa_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input mcpa_pkg::req_type       req_data,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input mcpa_pkg::rsp_type       rsp_data
);

   // a stalled response stays up
   `MCPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // a sample request keeps the block busy
   `MCPA_ASSERT_NEXT(a_busy, req_valid && req_ready && req_data.func, !req_ready)
   // a stalled response keeps its payload
   `MCPA_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))
   // reset drops the response
   `MCPA_ASSERT_ALWAYS(a_reset, reset, !rsp_valid)

endmodule

bind max_call_payoff_accumulator_core mcpa_checker u_mcpa_checker (.*);

FILE: tb/tb_max_call_payoff_accumulator_core.sv
// Testbench for the max-call payoff accumulator core: random and directed requests, scoreboard.
`timescale 1ns / 1ps
module tb_max_call_payoff_accumulator_core;

   localparam longint EXP_BOUND = 64'sd23 <<< 24;
   localparam longint LOG2E_Q30_TB = 64'sd1549082005;
   localparam longint unsigned LN2_Q30_TB = 64'd744261118;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 150;

   // Expected-response store with its own copy of the accumulator state
   class payoff_scoreboard;
      logic signed [31:0] drift_tab[64];
      logic [30:0] vol_tab[64];
      logic [31:0] spot_tab[64];
      bit loaded[64];
      int unsigned position;
      logic [31:0] up_max, down_max;
      logic [63:0] total;
      logic [39:0] paths;
      logic [6:0] count_reg;
      logic [31:0] strike_reg;
      mcpa_pkg::rsp_type pending[$];
      int errors;
      int responses;

      function new();
         position = 0;
         up_max = '0;
         down_max = '0;
         total = '0;
         paths = '0;
         count_reg = 7'd1;
         strike_reg = '0;
         errors = 0;
         responses = 0;
         foreach (loaded[i]) loaded[i] = 0;
      endfunction

      function void write_reg(mcpa_pkg::csr_index_type idx, logic [31:0] v);
         if (idx == mcpa_pkg::CSR_BASKET_SIZE) count_reg = v[6:0];
         else strike_reg = v;
      endfunction

      function int unsigned clamped_count();
         if (count_reg < 1) return 1;
         if (count_reg > 64) return 64;
         return count_reg;
      endfunction

      // spot * exp(x) in Q16.16, floored and saturated
      function logic [31:0] price(logic [31:0] spot, longint x);
         longint unsigned yb, f30, t, term, mant, prod;
         int n, s;
         if (x >= EXP_BOUND) return (spot != 0) ? 32'hFFFF_FFFF : 32'd0;
         if (x <= -EXP_BOUND) return 32'd0;
         yb = longint'(x * LOG2E_Q30_TB + (64'sd64 <<< 54));
         n = int'(yb >> 54) - 64;
         f30 = (yb & ((64'd1 << 54) - 64'd1)) >> 24;
         t = (f30 * LN2_Q30_TB) >> 30;
         term = 64'd1 << 30;
         mant = term;
         for (int i = 1; i <= 10; i++) begin
            term = ((term * t) >> 30) / longint'(i);
            mant += term;
         end
         prod = {32'd0, spot} * mant;
         s = 30 - n;
         if (s <= 0) begin
            if (prod > (64'hFFFF_FFFF >> (-s))) return 32'hFFFF_FFFF;
            return 32'(prod << (-s));
         end
         if (s >= 64) return 32'd0;
         prod = prod >> s;
         return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      endfunction

      function void note_request(mcpa_pkg::req_type r);
         int unsigned pos;
         longint g, gmag, dmag, d, drift;
         logic [31:0] up, down, pay_up, pay_dn;
         logic [63:0] payoff;
         mcpa_pkg::rsp_type e;
         if (r.func == 1'b0) begin
            drift_tab[r.stock_index] = r.drift_term;
            vol_tab[r.stock_index] = r.vol_root_time;
            spot_tab[r.stock_index] = r.spot_price;
            loaded[r.stock_index] = 1;
            return;
         end
         pos = (position > 63) ? 63 : position;
         g = longint'(r.gauss_sample);
         gmag = (g < 0) ? -g : g;
         dmag = (gmag * longint'({33'd0, vol_tab[pos]}) + (64'sd1 <<< 19)) >>> 20;
         d = (g < 0) ? -dmag : dmag;
         drift = longint'(drift_tab[pos]);
         up = price(spot_tab[pos], drift + d);
         down = price(spot_tab[pos], drift - d);
         if (up > up_max) up_max = up;
         if (down > down_max) down_max = down;
         if (pos + 1 < clamped_count()) begin
            position = pos + 1;
            return;
         end
         // path complete
         pay_up = (up_max > strike_reg) ? up_max - strike_reg : 32'd0;
         pay_dn = (down_max > strike_reg) ? down_max - strike_reg : 32'd0;
         payoff = {32'd0, pay_up} + {32'd0, pay_dn};
         if (total > ~64'd0 - payoff) total = ~64'd0;
         else total = total + payoff;
         paths = paths + 40'd1;
         position = 0;
         up_max = '0;
         down_max = '0;
         e.path_payoff = payoff[32:0];
         e.payoff_sum = total;
         e.path_count = paths;
         pending.push_back(e);
      endfunction

      function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %0h actual %0h", what, exp_v, act_v);
      endfunction

      function void check_response(mcpa_pkg::rsp_type r);
         mcpa_pkg::rsp_type e;
         responses++;
         if (pending.size() == 0) begin
            report("unexpected response", 0, r.path_count);
            return;
         end
         e = pending.pop_front();
         if (r.path_payoff !== e.path_payoff) report("path_payoff", e.path_payoff, r.path_payoff);
         if (r.payoff_sum !== e.payoff_sum) report("payoff_sum", e.payoff_sum, r.payoff_sum);
         if (r.path_count !== e.path_count) report("path_count", e.path_count, r.path_count);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   mcpa_pkg::req_type req_data;
   logic rsp_valid, rsp_ready;
   mcpa_pkg::rsp_type rsp_data;
   logic csr_valid, csr_ready;
   mcpa_pkg::csr_index_type csr_index;
   logic [31:0] csr_wdata;

   payoff_scoreboard board;
   bit quiet;
   bit hold_off;
   int cycles = 0;

   max_call_payoff_accumulator_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function int draw_gap();
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   // Offer one request and wait for its handshake
   task push_request(mcpa_pkg::req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      board.note_request(r);
   endtask

   task drive_load(logic [5:0] idx, logic [31:0] drift, logic [30:0] vol, logic [31:0] spot);
      mcpa_pkg::req_type r;
      r = '0;
      r.func = 1'b0;
      r.stock_index = idx;
      r.drift_term = drift;
      r.vol_root_time = vol;
      r.spot_price = spot;
      r.gauss_sample = 24'($urandom);
      push_request(r);
   endtask

   task drive_sample(logic [23:0] g);
      mcpa_pkg::req_type r;
      r = '0;
      r.func = 1'b1;
      r.stock_index = 6'($urandom);
      r.drift_term = $urandom;
      r.vol_root_time = 31'($urandom);
      r.spot_price = $urandom;
      r.gauss_sample = g;
      push_request(r);
   endtask

   task write_csr(mcpa_pkg::csr_index_type idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      board.write_reg(idx, v);
      @(posedge clock);
   endtask

   // Let everything drain before touching registers
   task drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random load: mostly realistic market values, sometimes raw bits
   task random_load(logic [5:0] idx);
      if ($urandom_range(0, 9) == 0)
         drive_load(idx, $urandom, 31'($urandom), $urandom);
      else
         drive_load(idx, 32'($urandom_range(0, 1 << 25) - (1 << 24)),
                    31'($urandom_range(0, 1 << 23)),
                    32'($urandom_range(1 << 16, 1000 << 16)));
   endtask

   // One random request; samples only touch loaded table entries
   task random_item();
      int unsigned pos;
      pos = (board.position > 63) ? 63 : board.position;
      if (!board.loaded[pos]) begin
         random_load(6'(pos));
      end else if ($urandom_range(0, 7) == 0) begin
         random_load(6'($urandom_range(0, 63)));
      end else if ($urandom_range(0, 9) == 0) begin
         drive_sample(24'($urandom));
      end else begin
         drive_sample(24'($urandom_range(0, 6 << 20) - (3 << 20)));
      end
   endtask

   // Response side
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0 || hold_off) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         board.check_response(rsp_data);
         @(posedge clock);
      end
   end

   // Long receiver stall once a few paths are done
   initial begin
      hold_off = 0;
      @(negedge reset);
      while (board.responses < 3) @(posedge clock);
      hold_off = 1;
      repeat (3000) @(posedge clock);
      hold_off = 0;
   end

   // Main sequence
   initial begin
      logic [6:0] counts[8];
      logic [31:0] strikes[8];
      quiet = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = mcpa_pkg::CSR_BASKET_SIZE;
      csr_wdata = '0;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: exponent limits, zero spot, field extremes
      write_csr(mcpa_pkg::CSR_BASKET_SIZE, 32'd4);
      write_csr(mcpa_pkg::CSR_STRIKE, 32'd0);
      drive_load(6'd0, 32'h7FFF_FFFF, 31'd0, 32'hFFFF_FFFF);
      drive_load(6'd1, 32'h8000_0000, 31'h7FFF_FFFF, 32'd1);
      drive_load(6'd2, 32'd24 << 24, 31'd1 << 22, 32'd0);
      drive_load(6'd3, 32'd0, 31'd1 << 23, 32'd100 << 16);
      drive_load(6'd63, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      drive_sample(24'h7FFFFF);
      drive_sample(24'h800000);
      drive_sample(24'h000000);
      drive_sample(24'h100000);
      drive_sample(24'hF00000);
      drive_sample(24'h7FFFFF);
      drive_sample(24'h800000);
      drive_sample(24'h000001);
      drain();

      counts = '{7'd3, 7'd1, 7'd0, 7'd64, 7'd127, 7'd5, 7'd2, 7'd8};
      strikes = '{32'd50 << 16, 32'hFFFF_FFFF, 32'd0, 32'd200 << 16,
                  32'd100 << 16, 32'd0, 32'd300 << 16, 32'd80 << 16};
      for (int p = 0; p < 8; p++) begin
         quiet = (p % 3 == 2);
         write_csr(mcpa_pkg::CSR_BASKET_SIZE, 32'(counts[p]));
         write_csr(mcpa_pkg::CSR_STRIKE, (p == 7) ? $urandom : strikes[p]);
         for (int k = 0; k < 180; k++) random_item();
         drain();
      end

      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+design
design/mcpa_pkg.sv
design/mcpa_tables.sv
design/mcpa_mult.sv
design/max_call_payoff_accumulator_core.sv
design/mcpa_checker.sv
tb/tb_max_call_payoff_accumulator_core.sv
